FILE: src/fcull_pkg.sv
// Shared types and constants for the frustum culling test
package fcull_pkg;

  // Payload field widths
  localparam int ACT_W = 2;
  localparam int FLD_W = 32;
  localparam int NRM_W = 16;
  localparam int CFG_W = 48;
  localparam int IDX_W = 3;

  // Side planes, normal components per plane
  localparam int SIDE_N = 4;
  localparam int COMP_N = 3;
  localparam int PLANE_N = 6;

  // Internal coordinate: covers any coordinate width once extended
  localparam int CRD_W = FLD_W + 1;
  // Normal times coordinate
  localparam int PROD_W = NRM_W + CRD_W;
  // Three products plus the sphere bias (radius << 14), with headroom
  localparam int ACC_W = PROD_W + 3;
  // Depth plane distance: z, depth and radius terms
  localparam int DEP_W = CRD_W + 2;
  // Sphere radius scale for the Q18.30 side distances
  localparam int RAD_SH = 14;

  // Item kinds
  localparam logic [ACT_W-1:0] ACT_POINT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SPHERE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CORNER = 2'd2;
  localparam logic [ACT_W-1:0] ACT_RAY    = 2'd3;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_LEFT   = 3'd0;
  localparam logic [IDX_W-1:0] REG_RIGHT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_BOTTOM = 3'd2;
  localparam logic [IDX_W-1:0] REG_TOP    = 3'd3;
  localparam logic [IDX_W-1:0] REG_NEAR   = 3'd4;
  localparam logic [IDX_W-1:0] REG_FAR    = 3'd5;

  // Far depth after reset: 10.0 in Q16.16
  localparam logic [FLD_W-1:0] FAR_RESET = 32'd655360;

  // Plane bit positions in the masks
  localparam int BIT_NEAR = 4;
  localparam int BIT_FAR  = 5;

  // Item as it walks along the cell row
  typedef struct packed {
    logic [ACT_W-1:0]                   action;
    logic                               skip_far;
    logic                               last_corner;
    logic [FLD_W-1:0]                   radius;
    logic [COMP_N-1:0][CRD_W-1:0]       crd;
    logic [SIDE_N-1:0][ACC_W-1:0]       acc;
  } cell_data_t;

  typedef logic [SIDE_N-1:0][NRM_W-1:0] comp_nrm_t;

endpackage

FILE: src/fcull_if.sv
// Valid/ready channel interfaces for items and results
interface fcull_in_if;
  import fcull_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic                    skip_far;
  logic signed [FLD_W-1:0] x_coord;
  logic signed [FLD_W-1:0] y_coord;
  logic signed [FLD_W-1:0] z_coord;
  logic [FLD_W-1:0]        sphere_radius;
  logic                    last_corner;

  modport source (output valid, action, skip_far, x_coord, y_coord, z_coord,
                  sphere_radius, last_corner, input ready);
  modport sink (input valid, action, skip_far, x_coord, y_coord, z_coord,
                sphere_radius, last_corner, output ready);
endinterface

interface fcull_out_if;
  import fcull_pkg::*;

  logic             valid;
  logic             ready;
  logic             inside_res;
  logic [ACT_W-1:0] answered_action;

  modport source (output valid, inside_res, answered_action, input ready);
  modport sink (input valid, inside_res, answered_action, output ready);
endinterface

FILE: src/fcull_cell.sv
// One multiply-accumulate cell: for each side plane, adds one normal component times one coordinate
module fcull_cell #(
  parameter int COMP_IDX = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fcull_pkg::comp_nrm_t   nrm,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  fcull_pkg::cell_data_t  up_data,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output fcull_pkg::cell_data_t  dn_data
);
  import fcull_pkg::*;

  localparam logic [1:0] CI = 2'(COMP_IDX);

  logic       valid_r;
  logic       valid_nxt;
  cell_data_t data_r;
  cell_data_t data_nxt;
  logic signed [PROD_W-1:0] prod [SIDE_N];

  // Stage is free when empty or when its content moves on
  assign up_ready = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  // One product per side plane, added to that plane's running sum
  always_comb begin
    data_nxt = up_data;
    for (int p = 0; p < SIDE_N; p++) begin
      prod[p] = $signed(nrm[p]) * $signed(up_data.crd[CI]);
      data_nxt.acc[p] = ACC_W'($signed(up_data.acc[p]) + ACC_W'(prod[p]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

FILE: src/fcull_decide.sv
// Plane tests, box mask and the result register
module fcull_decide (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [fcull_pkg::FLD_W-1:0]  near_depth,
  input  logic [fcull_pkg::FLD_W-1:0]  far_depth,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  fcull_pkg::cell_data_t        up_data,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic                         res_inside,
  output logic [fcull_pkg::ACT_W-1:0]  res_action
);
  import fcull_pkg::*;

  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic                   inside_r;
  logic                   inside_nxt;
  logic [ACT_W-1:0]       action_r;
  logic [PLANE_N-1:0]     hit_r;
  logic [PLANE_N-1:0]     hit_nxt;
  logic [PLANE_N-1:0]     outm;
  logic [PLANE_N-1:0]     use_m;
  logic [PLANE_N-1:0]     hit_upd;
  logic signed [DEP_W-1:0] z_ext;
  logic signed [DEP_W-1:0] rbias;
  logic signed [DEP_W-1:0] near_dist;
  logic signed [DEP_W-1:0] far_dist;
  logic                   is_corner;
  logic                   gives_res;
  logic                   slot_free;
  logic                   take;

  // Depth distances, radius added for spheres
  always_comb begin
    z_ext = DEP_W'($signed(up_data.crd[2]));
    rbias = (up_data.action == ACT_SPHERE) ?
            DEP_W'($signed({1'b0, up_data.radius})) : '0;
    near_dist = z_ext - DEP_W'($signed({1'b0, near_depth})) + rbias;
    far_dist  = DEP_W'($signed({1'b0, far_depth})) - z_ext + rbias;
  end

  // Outside mask: sign of each plane distance
  always_comb begin
    for (int p = 0; p < SIDE_N; p++) begin
      outm[p] = up_data.acc[p][ACC_W-1];
    end
    outm[BIT_NEAR] = near_dist[DEP_W-1];
    outm[BIT_FAR]  = far_dist[DEP_W-1];
    use_m = '1;
    use_m[BIT_FAR] = !up_data.skip_far;
    hit_upd = hit_r | ~outm;
  end

  // Handshake: box corners before the last are absorbed without a result
  assign is_corner = (up_data.action == ACT_CORNER);
  assign gives_res = !is_corner || up_data.last_corner;
  assign slot_free = !out_valid_r || res_ready;
  assign up_ready  = !gives_res || slot_free;
  assign take      = up_valid && up_ready;

  // Verdict for the item and mask update
  always_comb begin
    hit_nxt = hit_r;
    case (up_data.action)
      ACT_POINT, ACT_SPHERE: begin
        inside_nxt = ((outm & use_m) == '0);
      end
      ACT_CORNER: begin
        inside_nxt = ((~hit_upd & use_m) == '0);
        if (take) begin
          hit_nxt = up_data.last_corner ? '0 : hit_upd;
        end
      end
      ACT_RAY: begin
        inside_nxt = (outm[SIDE_N-1:0] == '0);
      end
      default: begin
        inside_nxt = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (take && gives_res) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hit_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      hit_r       <= hit_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (take && gives_res) begin
      inside_r <= inside_nxt;
      action_r <= up_data.action;
    end
  end

  assign res_valid  = out_valid_r;
  assign res_inside = inside_r;
  assign res_action = action_r;

endmodule

FILE: src/frustum_cull_test.sv
// Top level of the six-plane frustum culling test
//
//  channel   dir  handshake          payload
//  in_chan   in   valid/ready        action, skip_far, x/y/z_coord, sphere_radius, last_corner
//  out_chan  out  valid/ready        inside_res, answered_action
//  cfg_*     in   cfg_we             cfg_index, cfg_data
//
// One transaction per cycle is taken in while no output stall holds the row; a result
// passes through the three multiply-accumulate cells (one per normal component) and the
// decision register. Box corners other than the last give no result.
// Synchronous active-low reset empties the row and clears the box mask.
// A stall at the output holds each full cell only while the cell after it is full.
module frustum_cull_test #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  fcull_in_if.sink                      in_chan,
  fcull_out_if.source                   out_chan,
  input  logic                          cfg_we,
  input  logic [fcull_pkg::IDX_W-1:0]   cfg_index,
  input  logic [fcull_pkg::CFG_W-1:0]   cfg_data
);
  import fcull_pkg::*;

  localparam int SH = (COORD_WIDTH < FLD_W) ? FLD_W - COORD_WIDTH : 0;
  localparam bit WIDE = (COORD_WIDTH > FLD_W);

  logic [SIDE_N-1:0][CFG_W-1:0] side_nrm_r;
  logic [FLD_W-1:0]             near_r;
  logic [FLD_W-1:0]             far_r;

  comp_nrm_t                    cell_nrm [COMP_N];
  logic                         stg_valid [COMP_N+1];
  logic                         stg_ready [COMP_N+1];
  cell_data_t                   stg_data  [COMP_N+1];
  logic signed [FLD_W-1:0]      raw [COMP_N];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_nrm_r <= '0;
      near_r     <= '0;
      far_r      <= FAR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT:   side_nrm_r[0] <= cfg_data;
        REG_RIGHT:  side_nrm_r[1] <= cfg_data;
        REG_BOTTOM: side_nrm_r[2] <= cfg_data;
        REG_TOP:    side_nrm_r[3] <= cfg_data;
        REG_NEAR:   near_r <= cfg_data[FLD_W-1:0];
        REG_FAR:    far_r  <= cfg_data[FLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Normal component k of every side plane feeds cell k
  always_comb begin
    for (int k = 0; k < COMP_N; k++) begin
      for (int p = 0; p < SIDE_N; p++) begin
        cell_nrm[k][p] = side_nrm_r[p][NRM_W*k +: NRM_W];
      end
    end
  end

  // Entry: coordinates taken at COORD_WIDTH bits, sphere bias preloaded
  assign raw[0] = in_chan.x_coord;
  assign raw[1] = in_chan.y_coord;
  assign raw[2] = in_chan.z_coord;

  always_comb begin
    stg_data[0].action      = in_chan.action;
    stg_data[0].skip_far    = in_chan.skip_far;
    stg_data[0].last_corner = in_chan.last_corner;
    stg_data[0].radius      = in_chan.sphere_radius;
    for (int k = 0; k < COMP_N; k++) begin
      if (WIDE) begin
        stg_data[0].crd[k] = {1'b0, raw[k]};
      end else begin
        // shift out the high bits at field width, then sign-extend back
        stg_data[0].crd[k] = CRD_W'(FLD_W'(raw[k] <<< SH) >>> SH);
      end
    end
    for (int p = 0; p < SIDE_N; p++) begin
      stg_data[0].acc[p] = (in_chan.action == ACT_SPHERE) ?
                           ACC_W'({in_chan.sphere_radius, {RAD_SH{1'b0}}}) : '0;
    end
  end

  assign stg_valid[0]  = in_chan.valid;
  assign in_chan.ready = stg_ready[0];

  // Row of multiply-accumulate cells
  for (genvar k = 0; k < COMP_N; k++) begin : g_cell
    fcull_cell #(
      .COMP_IDX (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .nrm      (cell_nrm[k]),
      .up_valid (stg_valid[k]),
      .up_ready (stg_ready[k]),
      .up_data  (stg_data[k]),
      .dn_valid (stg_valid[k+1]),
      .dn_ready (stg_ready[k+1]),
      .dn_data  (stg_data[k+1])
    );
  end

  // Plane verdicts, box mask and result register
  fcull_decide u_decide (
    .clk        (clk),
    .rst_n      (rst_n),
    .near_depth (near_r),
    .far_depth  (far_r),
    .up_valid   (stg_valid[COMP_N]),
    .up_ready   (stg_ready[COMP_N]),
    .up_data    (stg_data[COMP_N]),
    .res_valid  (out_chan.valid),
    .res_ready  (out_chan.ready),
    .res_inside (out_chan.inside_res),
    .res_action (out_chan.answered_action)
  );

endmodule

FILE: tb/testbench.sv
// Self-checking bench for the frustum culling block: directed table, then random phases
`timescale 1ns / 1ps

module testbench;
  import fcull_pkg::*;

  // Q16.16 and Q2.14 values used by the stimulus
  localparam logic signed [FLD_W-1:0] Q0   = 32'sh0000_0000;
  localparam logic signed [FLD_W-1:0] Q1   = 32'sh0001_0000;
  localparam logic signed [FLD_W-1:0] QMAX = 32'sh7FFF_FFFF;
  localparam logic signed [FLD_W-1:0] QMIN = 32'sh8000_0000;
  localparam logic [FLD_W-1:0]        R0   = 32'h0000_0000;
  localparam logic [FLD_W-1:0]        RMAX = 32'hFFFF_FFFF;
  localparam int                      N1   = 16384;
  localparam logic [NRM_W-1:0]        NRM_MIN = 16'h8000;
  localparam logic [NRM_W-1:0]        NRM_MAX = 16'h7FFF;

  // Register indexes outside the map; writes to them must be dropped
  localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam logic [PLANE_N-1:0] ALL_PLANES  = '1;
  localparam logic [PLANE_N-1:0] SIDE_PLANES = 6'h0F;
  localparam logic [PLANE_N-1:0] FAR_MASK    = 6'(1 << BIT_FAR);

  localparam int RESET_ROWS   = 16;
  localparam int DIRECTED_N   = 27;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 175;
  localparam int SETTLE       = 10;
  localparam int QUIET_LIMIT  = 2000;

  typedef enum {PLANES_REALISTIC, PLANES_RANDOM, PLANES_EXTREME, PLANES_CROSSED} plane_set_t;
  typedef enum {RX_OPEN, RX_BUSY, RX_CHOKED, RX_HOLD} rx_mode_t;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic                    skip_far;
    logic                    last;
    logic signed [FLD_W-1:0] x;
    logic signed [FLD_W-1:0] y;
    logic signed [FLD_W-1:0] z;
    logic [FLD_W-1:0]        radius;
  } cull_item_t;

  typedef struct packed {
    cull_item_t item;
    logic       fixed;
    logic       verdict;
  } cull_row_t;

  typedef struct packed {
    logic             kept;
    logic [ACT_W-1:0] action;
  } cull_res_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  // Side channel: a hand-written verdict travelling with the item being offered
  logic drv_fixed;
  logic drv_verdict;

  fcull_in_if  in_chan ();
  fcull_out_if out_chan ();

  frustum_cull_test dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the plane registers and the box mask
  logic [SIDE_N-1:0][CFG_W-1:0] side_nrm    = '0;
  logic [FLD_W-1:0]             near_d      = '0;
  logic [FLD_W-1:0]             far_d       = FAR_RESET;
  logic [PLANE_N-1:0]           box_reached = '0;

  cull_res_t pending_verdicts[$];
  int        fail_count  = 0;
  int        quiet_cycles = 0;
  int        burst_left  = 0;
  int        items_sent  = 0;
  rx_mode_t  rx_mode     = RX_OPEN;
  int        rx_left     = 0;

  // Directed table: first rows run on reset planes, the rest on a 90 degree frustum
  cull_row_t directed_rows [DIRECTED_N] = '{
    // reset planes: zero side normals, near 0.0, far 10.0
    '{'{ACT_POINT,  1'b0, 1'b0, Q0,   Q0,   Q0,     R0},   1'b1, 1'b1},
    '{'{ACT_POINT,  1'b0, 1'b0, Q0,   Q0,   -Q1,    R0},   1'b1, 1'b0},
    '{'{ACT_POINT,  1'b0, 1'b0, Q0,   Q0,   11*Q1,  R0},   1'b1, 1'b0},
    '{'{ACT_POINT,  1'b1, 1'b0, Q0,   Q0,   11*Q1,  R0},   1'b1, 1'b1},
    '{'{ACT_POINT,  1'b0, 1'b1, QMAX, QMIN, QMIN,   RMAX}, 1'b1, 1'b0},
    '{'{ACT_POINT,  1'b1, 1'b0, QMIN, QMAX, QMAX,   R0},   1'b1, 1'b1},
    // sphere touching the near plane, then one step further out
    '{'{ACT_SPHERE, 1'b0, 1'b0, Q0,   Q0,   -Q1,    Q1},   1'b1, 1'b1},
    '{'{ACT_SPHERE, 1'b0, 1'b0, Q0,   Q0,   -Q1-1,  Q1},   1'b1, 1'b0},
    '{'{ACT_SPHERE, 1'b0, 1'b0, QMAX, QMIN, QMIN,   RMAX}, 1'b1, 1'b1},
    '{'{ACT_RAY,    1'b1, 1'b1, QMIN, QMIN, QMIN,   RMAX}, 1'b1, 1'b1},
    // box with a point slipped in between its corners
    '{'{ACT_CORNER, 1'b0, 1'b0, Q0,   Q0,   -Q1,    RMAX}, 1'b0, 1'b0},
    '{'{ACT_POINT,  1'b0, 1'b0, Q0,   Q0,   -Q1,    R0},   1'b1, 1'b0},
    '{'{ACT_CORNER, 1'b0, 1'b1, Q0,   Q0,   11*Q1,  R0},   1'b1, 1'b1},
    // box wholly behind the near plane
    '{'{ACT_CORNER, 1'b1, 1'b0, QMAX, QMAX, -Q1,    R0},   1'b0, 1'b0},
    '{'{ACT_CORNER, 1'b0, 1'b1, QMIN, Q0,   -2*Q1,  R0},   1'b1, 1'b0},
    // one-corner box past the far plane, far plane dropped
    '{'{ACT_CORNER, 1'b1, 1'b1, Q0,   Q0,   12*Q1,  R0},   1'b1, 1'b1},
    // 90 degree frustum, near 0.5, far 10.0
    '{'{ACT_POINT,  1'b0, 1'b0, Q0,     Q0,    5*Q1, R0},   1'b0, 1'b0},
    '{'{ACT_POINT,  1'b0, 1'b0, -6*Q1,  Q0,    5*Q1, R0},   1'b0, 1'b0},
    '{'{ACT_POINT,  1'b0, 1'b0, -5*Q1,  5*Q1,  5*Q1, R0},   1'b0, 1'b0},
    '{'{ACT_SPHERE, 1'b0, 1'b0, -6*Q1,  Q0,    5*Q1, Q1/2}, 1'b0, 1'b0},
    '{'{ACT_SPHERE, 1'b0, 1'b0, -6*Q1,  Q0,    5*Q1, Q1},   1'b0, 1'b0},
    '{'{ACT_RAY,    1'b0, 1'b0, Q0,     Q0,    -Q1,  R0},   1'b0, 1'b0},
    '{'{ACT_RAY,    1'b0, 1'b0, Q1,     -Q1,   Q1,   R0},   1'b0, 1'b0},
    '{'{ACT_CORNER, 1'b0, 1'b0, -6*Q1,  Q0,    5*Q1, R0},   1'b0, 1'b0},
    '{'{ACT_CORNER, 1'b0, 1'b1, 6*Q1,   Q0,    5*Q1, R0},   1'b0, 1'b0},
    '{'{ACT_CORNER, 1'b0, 1'b0, -6*Q1,  Q0,    5*Q1, R0},   1'b0, 1'b0},
    '{'{ACT_CORNER, 1'b0, 1'b1, -7*Q1,  Q0,    3*Q1, R0},   1'b0, 1'b0}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Planes failed by an item: side distances in Q18.30, depth distances in Q16.16
  function automatic logic [PLANE_N-1:0] planes_failed(input cull_item_t it,
                                                       input longint side_bias,
                                                       input longint depth_bias);
    logic [PLANE_N-1:0] m;
    longint reach;
    m = '0;
    for (int p = 0; p < SIDE_N; p++) begin
      reach = side_bias;
      reach += longint'(signed'(side_nrm[p][15:0]))  * longint'(it.x);
      reach += longint'(signed'(side_nrm[p][31:16])) * longint'(it.y);
      reach += longint'(signed'(side_nrm[p][47:32])) * longint'(it.z);
      m[p] = reach < 0;
    end
    m[BIT_NEAR] = longint'(it.z) - longint'(near_d) + depth_bias < 0;
    m[BIT_FAR]  = longint'(far_d) - longint'(it.z) + depth_bias < 0;
    return m;
  endfunction

  // Verdict for one item; returns 0 when the item gives no result
  function automatic bit predict_verdict(input cull_item_t it, output cull_res_t res);
    logic [PLANE_N-1:0] in_use;
    in_use = it.skip_far ? (ALL_PLANES & ~FAR_MASK) : ALL_PLANES;
    res.action = it.action;
    res.kept   = 1'b0;
    case (it.action)
      ACT_POINT: res.kept = (planes_failed(it, 0, 0) & in_use) == '0;
      ACT_SPHERE: begin
        res.kept = (planes_failed(it, longint'(it.radius) <<< RAD_SH,
                                  longint'(it.radius)) & in_use) == '0;
      end
      ACT_CORNER: begin
        box_reached |= ~planes_failed(it, 0, 0);
        if (!it.last)
          return 1'b0;
        res.kept    = (~box_reached & in_use) == '0;
        box_reached = '0;
      end
      ACT_RAY: res.kept = (planes_failed(it, 0, 0) & SIDE_PLANES) == '0;
      default: ;
    endcase
    return 1'b1;
  endfunction

  function automatic logic [CFG_W-1:0] nrm_pack(input int nx, input int ny, input int nz);
    return {16'(nz), 16'(ny), 16'(nx)};
  endfunction

  function automatic logic signed [FLD_W-1:0] rand_coord(input bit depth);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? QMAX : QMIN;
      default: begin
        if (depth)
          return $urandom_range(0, 24*Q1) - 2*Q1;
        return $urandom_range(0, 40*Q1) - 20*Q1;
      end
    endcase
  endfunction

  function automatic logic [FLD_W-1:0] rand_radius();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return $urandom;
      default: return $urandom_range(0, 4*Q1);
    endcase
  endfunction

  function automatic cull_item_t rand_item();
    cull_item_t it;
    it.action   = ACT_W'($urandom_range(0, 3));
    it.skip_far = 1'($urandom_range(0, 1));
    it.last     = 1'($urandom_range(0, 1));
    it.x        = rand_coord(1'b0);
    it.y        = rand_coord(1'b0);
    it.z        = rand_coord(1'b1);
    it.radius   = rand_radius();
    return it;
  endfunction

  // Offer one item, with a random gap between bursts; returns once it is taken
  task automatic send_item(input cull_item_t it, input bit fixed, input bit verdict);
    if (burst_left == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
    end
    burst_left--;
    items_sent++;
    in_chan.valid         <= 1'b1;
    in_chan.action        <= it.action;
    in_chan.skip_far      <= it.skip_far;
    in_chan.x_coord       <= it.x;
    in_chan.y_coord       <= it.y;
    in_chan.z_coord       <= it.z;
    in_chan.sphere_radius <= it.radius;
    in_chan.last_corner   <= it.last;
    drv_fixed             <= fixed;
    drv_verdict           <= verdict;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Corners of one box around a random centre, now and then with stray items between
  task automatic send_box();
    int n;
    bit broken;
    logic signed [FLD_W-1:0] cx, cy, cz, hx, hy, hz;
    cull_item_t it;
    n = $urandom_range(1, 8);
    broken = ($urandom_range(0, 9) == 0);
    cx = rand_coord(1'b0);
    cy = rand_coord(1'b0);
    cz = rand_coord(1'b1);
    hx = $urandom_range(0, 3*Q1);
    hy = $urandom_range(0, 3*Q1);
    hz = $urandom_range(0, 3*Q1);
    for (int k = 0; k < n; k++) begin
      if (k != 0 && $urandom_range(0, 7) == 0)
        send_item(rand_item(), 1'b0, 1'b0);
      it.action   = ACT_CORNER;
      it.skip_far = 1'($urandom_range(0, 1));
      it.last     = (k == n - 1) && !broken;
      it.x        = $urandom_range(0, 1) ? cx + hx : cx - hx;
      it.y        = $urandom_range(0, 1) ? cy + hy : cy - hy;
      it.z        = $urandom_range(0, 1) ? cz + hz : cz - hz;
      it.radius   = $urandom;
      send_item(it, 1'b0, 1'b0);
    end
  endtask

  // Stop offering, wait for every outstanding verdict, then let the pipe settle
  task automatic drain();
    in_chan.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_LEFT:   side_nrm[0] = data;
      REG_RIGHT:  side_nrm[1] = data;
      REG_BOTTOM: side_nrm[2] = data;
      REG_TOP:    side_nrm[3] = data;
      REG_NEAR:   near_d = data[FLD_W-1:0];
      REG_FAR:    far_d  = data[FLD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_planes(input logic [SIDE_N-1:0][CFG_W-1:0] nrm,
                                input logic [CFG_W-1:0] near_w, input logic [CFG_W-1:0] far_w);
    cfg_put(REG_LEFT, nrm[0]);
    cfg_put(REG_RIGHT, nrm[1]);
    cfg_put(REG_BOTTOM, nrm[2]);
    cfg_put(REG_TOP, nrm[3]);
    cfg_put(REG_NEAR, near_w);
    cfg_put(REG_FAR, far_w);
    cfg_put($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, {$urandom, 16'($urandom)});
    cfg_we <= 1'b0;
  endtask

  task automatic load_plane_set(input plane_set_t kind);
    logic [SIDE_N-1:0][CFG_W-1:0] nrm;
    logic [CFG_W-1:0] near_w, far_w;
    case (kind)
      PLANES_RANDOM: begin
        for (int p = 0; p < SIDE_N; p++)
          nrm[p] = CFG_W'({$urandom, $urandom});
        near_w = {16'($urandom), 32'($urandom)};
        far_w  = {16'($urandom), 32'($urandom)};
      end
      PLANES_EXTREME: begin
        nrm[0] = {NRM_MIN, NRM_MIN, NRM_MIN};
        nrm[1] = {NRM_MAX, NRM_MAX, NRM_MAX};
        nrm[2] = {16'h0000, NRM_MAX, NRM_MIN};
        nrm[3] = '0;
        near_w = '0;
        far_w  = CFG_W'(RMAX);
      end
      default: begin
        // plausible camera: side normals lean inwards, far beyond near
        nrm[0] = nrm_pack($urandom_range(2048, 32767), 0, $urandom_range(0, 32767));
        nrm[1] = nrm_pack(-$urandom_range(2048, 32767), 0, $urandom_range(0, 32767));
        nrm[2] = nrm_pack(0, $urandom_range(2048, 32767), $urandom_range(0, 32767));
        nrm[3] = nrm_pack(0, -$urandom_range(2048, 32767), $urandom_range(0, 32767));
        near_w = CFG_W'($urandom_range(0, 2*Q1));
        far_w  = near_w + CFG_W'($urandom_range(Q1, 30*Q1));
        if (kind == PLANES_CROSSED) begin
          // far plane in front of the near one
          if ($urandom_range(0, 1)) begin
            near_w = CFG_W'(RMAX);
            far_w  = '0;
          end else begin
            near_w = CFG_W'($urandom_range(Q1, 20*Q1));
            far_w  = near_w - CFG_W'($urandom_range(1, Q1));
          end
        end
      end
    endcase
    program_planes(nrm, near_w, far_w);
  endtask

  // Result side: stall pattern that switches among open, busy, choked and hold modes
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(4, 40);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   out_chan.ready <= 1'b1;
      RX_BUSY:   out_chan.ready <= ($urandom_range(0, 3) != 0);
      RX_CHOKED: out_chan.ready <= ($urandom_range(0, 3) == 0);
      RX_HOLD:   out_chan.ready <= 1'b0;
      default:   out_chan.ready <= 1'b1;
    endcase
  end

  // Port watch: predict on every accepted item, check every accepted result
  always @(posedge clk) begin : port_watch
    cull_item_t took;
    cull_res_t  want;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        if (pending_verdicts.size() == 0) begin
          $error("unexpected result: inside_res=%0b answered_action=%0d",
                 out_chan.inside_res, out_chan.answered_action);
          fail_count++;
        end else begin
          want = pending_verdicts.pop_front();
          if (out_chan.inside_res !== want.kept) begin
            $error("inside_res: expected %0b, got %0b", want.kept, out_chan.inside_res);
            fail_count++;
          end
          if (out_chan.answered_action !== want.action) begin
            $error("answered_action: expected %0d, got %0d",
                   want.action, out_chan.answered_action);
            fail_count++;
          end
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        took.action   = in_chan.action;
        took.skip_far = in_chan.skip_far;
        took.last     = in_chan.last_corner;
        took.x        = in_chan.x_coord;
        took.y        = in_chan.y_coord;
        took.z        = in_chan.z_coord;
        took.radius   = in_chan.sphere_radius;
        if (predict_verdict(took, want)) begin
          if (drv_fixed)
            want.kept = drv_verdict;
          pending_verdicts.push_back(want);
        end
      end
    end
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
  end

  // Watchdog: too long with no transaction on any port
  initial begin : watchdog
    do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // Main sequence
  initial begin : stimulus
    int phase_end;
    plane_set_t kind;
    rst_n                 <= 1'b0;
    in_chan.valid         <= 1'b0;
    in_chan.action        <= ACT_POINT;
    in_chan.skip_far      <= 1'b0;
    in_chan.x_coord       <= '0;
    in_chan.y_coord       <= '0;
    in_chan.z_coord       <= '0;
    in_chan.sphere_radius <= '0;
    in_chan.last_corner   <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_index             <= REG_LEFT;
    cfg_data              <= '0;
    drv_fixed             <= 1'b0;
    drv_verdict           <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed table; switch to a square frustum part way through
    for (int i = 0; i < DIRECTED_N; i++) begin
      if (i == RESET_ROWS) begin
        drain();
        program_planes({nrm_pack(0, -N1, N1), nrm_pack(0, N1, N1),
                        nrm_pack(-N1, 0, N1), nrm_pack(N1, 0, N1)},
                       CFG_W'(Q1/2), CFG_W'(10*Q1));
      end
      send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].verdict);
    end

    // random phases, each on a fresh plane set loaded while idle
    for (int ph = 0; ph < PHASES; ph++) begin
      kind = (ph % 2 == 1) ? PLANES_REALISTIC : plane_set_t'((ph / 2) % 4);
      drain();
      load_plane_set(kind);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 9) < 4)
          send_item(rand_item(), 1'b0, 1'b0);
        else
          send_box();
      end
    end

    drain();
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
